### rtl/core/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types and constants for the bank copy address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bca_pkg;

  localparam int ROWS_W      = 12;
  localparam int GROUPS_W    = 8;
  localparam int SGRP_W      = 4;
  localparam int ADDR_W      = 16;
  localparam int MASK_W      = 8;
  localparam int BANK_ID_W   = 7;
  localparam int BYTES_W     = 9;
  localparam int BGRP_W      = 5;
  localparam int INPAR_W     = 7;
  localparam int OUTPAR_W    = 9;
  localparam int DIV_W       = 9;
  localparam int QDEPTH      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int BANKS_PER_GROUP_DEF = 8;

  localparam logic [BGRP_W-1:0]   BANK_GROUPS_RST  = BGRP_W'(4);
  localparam logic [INPAR_W-1:0]  IN_PARALLEL_RST  = INPAR_W'(16);
  localparam logic [OUTPAR_W-1:0] OUT_PARALLEL_RST = OUTPAR_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_GROUPS,
    CFG_IN_PARALLEL,
    CFG_OUT_PARALLEL
  } cfg_index_t;

  typedef struct packed {
    logic                action;
    logic [ROWS_W-1:0]   row_count;
    logic [GROUPS_W-1:0] channel_groups;
    logic [SGRP_W-1:0]   source_group;
    logic [ADDR_W-1:0]   source_base;
    logic [ADDR_W-1:0]   dest_base;
    logic [MASK_W-1:0]   bank_mask;
  } item_t;

  typedef struct packed {
    logic                 transfer_valid;
    logic                 bad_request;
    logic [BANK_ID_W-1:0] src_bank;
    logic [ADDR_W-1:0]    src_addr;
    logic [BANK_ID_W-1:0] dst_bank;
    logic [ADDR_W-1:0]    dst_addr;
    logic [BYTES_W-1:0]   byte_count;
    logic                 last_transfer;
  } result_t;

  typedef struct packed {
    logic [BGRP_W-1:0]   bank_groups;
    logic [INPAR_W-1:0]  in_parallel;
    logic [OUTPAR_W-1:0] out_parallel;
  } cfg_t;

  typedef enum logic [1:0] {
    QK_START,
    QK_REJECT,
    QK_STEP
  } qkind_t;

  typedef struct packed {
    qkind_t              kind;
    logic [ROWS_W-1:0]   row_count;
    logic [GROUPS_W-1:0] channel_groups;
    logic [SGRP_W-1:0]   source_group;
    logic [ADDR_W-1:0]   source_base;
    logic [ADDR_W-1:0]   dest_base;
    logic [MASK_W-1:0]   bank_mask;
  } qitem_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV_SCALE,
    BK_DIV_GROUP
  } back_state_t;

endpackage

`default_nettype wire

### rtl/core/bca_front.sv
// ----------------------------------------------------------------------------
// bca_front
// Accepts items, classifies them as start, rejected start or step, and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_front import bca_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   item_valid,
  output logic        item_ready,
  input  wire item_t  item,
  output logic        head_valid,
  output qitem_t      head,
  input  wire logic   pop
);

  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);

  qitem_t              slots [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [FILL_W-1:0]   fill;
  qitem_t              entry;
  logic                reject;
  logic                push;
  logic                take;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    reject = ({1'b0, item.source_group} >= cfg.bank_groups) ||
             (cfg.out_parallel < OUTPAR_W'(cfg.in_parallel)) ||
             (cfg.in_parallel == '0);
    entry.row_count      = item.row_count;
    entry.channel_groups = item.channel_groups;
    entry.source_group   = item.source_group;
    entry.source_base    = item.source_base;
    entry.dest_base      = item.dest_base;
    entry.bank_mask      = item.bank_mask;
    if (item.action) begin
      entry.kind = QK_STEP;
    end else if (reject) begin
      entry.kind = QK_REJECT;
    end else begin
      entry.kind = QK_START;
    end
  end

  assign item_ready = (fill != FILL_W'(QDEPTH));
  assign push       = item_valid && item_ready;
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (take) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !take) begin
        fill <= fill + FILL_W'(1);
      end else if (take && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bca_div.sv
// ----------------------------------------------------------------------------
// bca_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_div import bca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               running;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   quo;
  logic [DIV_W-1:0]   dvsr;
  logic [DIV_W:0]     shifted;
  logic [DIV_W:0]     diff;

  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (req.start) begin
        running <= 1'b1;
      end else if (running && (cnt == CNT_W'(1))) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
      cnt  <= CNT_W'(DIV_W);
    end else if (running) begin
      cnt <= cnt - CNT_W'(1);
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

### rtl/core/bca_back.sv
// ----------------------------------------------------------------------------
// bca_back
// Runs queued items: loads an instruction through the divider, then walks
// bank, row and channel group counters, one result per step (a transfer when busy).
// ----------------------------------------------------------------------------
`default_nettype none

module bca_back import bca_pkg::*; #(
  parameter int BANKS_PER_GROUP = BANKS_PER_GROUP_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     head_valid,
  input  wire qitem_t   head,
  output logic          pop,
  output div_req_t      div_req,
  input  wire div_rsp_t div_rsp,
  output logic          result_valid,
  input  wire logic     result_ready,
  output result_t       result
);

  localparam int BW = (BANKS_PER_GROUP > 1) ? $clog2(BANKS_PER_GROUP) : 1;

  back_state_t          state, state_next;
  logic                 busy, busy_next;
  logic                 result_valid_next;
  result_t              result_next;

  logic [MASK_W-1:0]    mask, mask_next;
  logic [ROWS_W-1:0]    rows, rows_next;
  logic [GROUPS_W-1:0]  groups, groups_next;
  logic [SGRP_W-1:0]    grp, grp_next;
  logic [ADDR_W-1:0]    src_base, src_base_next;
  logic [ADDR_W-1:0]    dst_base, dst_base_next;
  logic [DIV_W-1:0]     scale, scale_next;
  logic [GROUPS_W-1:0]  count, count_next;
  logic [BYTES_W-1:0]   rem_bytes, rem_bytes_next;
  logic [BW-1:0]        bank, bank_next;
  logic [ROWS_W-1:0]    row, row_next;
  logic [GROUPS_W-1:0]  gidx, gidx_next;
  logic [ADDR_W-1:0]    src_row, src_row_next;
  logic [ADDR_W-1:0]    src_addr, src_addr_next;
  logic [ADDR_W-1:0]    dst_addr, dst_addr_next;

  logic                 can_emit;
  logic                 last_group;
  logic                 last_row;
  logic [BW:0]          bank_inc;
  logic [BW:0]          nb;
  logic [BW:0]          fb;
  logic [BANK_ID_W-1:0] dgrp;
  logic [ADDR_W-1:0]    row_step;

  // {found, index} of the lowest enabled bank at or above from
  function automatic logic [BW:0] first_bank(input logic [MASK_W-1:0] m,
                                             input logic [BW:0] from);
    logic [BW:0] res;
    res = '0;
    for (int i = BANKS_PER_GROUP - 1; i >= 0; i--) begin
      if (m[i] && (i >= int'(from))) begin
        res = {1'b1, BW'(i)};
      end
    end
    return res;
  endfunction

  always_comb begin
    state_next        = state;
    busy_next         = busy;
    result_valid_next = result_valid && !result_ready;
    result_next       = result;
    mask_next         = mask;
    rows_next         = rows;
    groups_next       = groups;
    grp_next          = grp;
    src_base_next     = src_base;
    dst_base_next     = dst_base;
    scale_next        = scale;
    count_next        = count;
    rem_bytes_next    = rem_bytes;
    bank_next         = bank;
    row_next          = row;
    gidx_next         = gidx;
    src_row_next      = src_row;
    src_addr_next     = src_addr;
    dst_addr_next     = dst_addr;
    pop               = 1'b0;
    div_req           = '0;

    can_emit   = !result_valid || result_ready;
    last_group = ({1'b0, gidx} + 9'd1) == {1'b0, count};
    last_row   = ({1'b0, row} + 13'd1) == {1'b0, rows};
    bank_inc   = {1'b0, bank} + {{BW{1'b0}}, 1'b1};
    nb         = first_bank(mask, bank_inc);
    fb         = first_bank(mask, '0);
    dgrp       = BANK_ID_W'(cfg.bank_groups) - BANK_ID_W'(1);
    row_step   = src_row + ADDR_W'(groups);

    unique case (state)
      BK_RUN: begin
        if (head_valid) begin
          unique case (head.kind)
            QK_REJECT: begin
              if (can_emit) begin
                pop                     = 1'b1;
                busy_next               = 1'b0;
                result_valid_next       = 1'b1;
                result_next             = '0;
                result_next.bad_request = 1'b1;
              end
            end
            QK_START: begin
              pop              = 1'b1;
              busy_next        = 1'b0;
              mask_next        = head.bank_mask;
              rows_next        = head.row_count;
              groups_next      = head.channel_groups;
              grp_next         = head.source_group;
              src_base_next    = head.source_base;
              dst_base_next    = head.dest_base;
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(cfg.out_parallel);
              div_req.divisor  = DIV_W'(cfg.in_parallel);
              state_next       = BK_DIV_SCALE;
            end
            QK_STEP: begin
              if (can_emit) begin
                pop               = 1'b1;
                result_valid_next = 1'b1;
                result_next       = '0;
                if (busy) begin
                  result_next.transfer_valid = 1'b1;
                  result_next.src_bank = BANK_ID_W'(grp * BANKS_PER_GROUP) +
                                         BANK_ID_W'(bank);
                  result_next.src_addr = src_addr;
                  result_next.dst_bank = BANK_ID_W'(dgrp * BANKS_PER_GROUP) +
                                         BANK_ID_W'(bank);
                  result_next.dst_addr = dst_addr;
                  result_next.byte_count = last_group ? rem_bytes : cfg.out_parallel;
                  if (!last_group) begin
                    gidx_next     = gidx + GROUPS_W'(1);
                    src_addr_next = src_addr + ADDR_W'(scale);
                    dst_addr_next = dst_addr + ADDR_W'(1);
                  end else if (!last_row) begin
                    gidx_next     = '0;
                    row_next      = row + ROWS_W'(1);
                    src_row_next  = row_step;
                    src_addr_next = row_step;
                    dst_addr_next = dst_addr + ADDR_W'(1);
                  end else begin
                    gidx_next     = '0;
                    row_next      = '0;
                    src_row_next  = src_base;
                    src_addr_next = src_base;
                    dst_addr_next = dst_base;
                    if (nb[BW]) begin
                      bank_next = nb[BW-1:0];
                    end else begin
                      bank_next                 = '0;
                      busy_next                 = 1'b0;
                      result_next.last_transfer = 1'b1;
                    end
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_DIV_SCALE: begin
        if (div_rsp.done) begin
          scale_next       = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(groups);
          div_req.divisor  = div_rsp.quotient;
          state_next       = BK_DIV_GROUP;
        end
      end
      BK_DIV_GROUP: begin
        if (div_rsp.done) begin
          count_next     = GROUPS_W'(div_rsp.quotient) +
                           GROUPS_W'(div_rsp.remainder != '0);
          rem_bytes_next = (div_rsp.remainder != '0) ?
                           BYTES_W'(cfg.in_parallel * div_rsp.remainder) :
                           cfg.out_parallel;
          bank_next      = fb[BW-1:0];
          busy_next      = fb[BW] && (rows != '0) && (count_next != '0);
          row_next       = '0;
          gidx_next      = '0;
          src_row_next   = src_base;
          src_addr_next  = src_base;
          dst_addr_next  = dst_base;
          state_next     = BK_RUN;
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_RUN;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      busy         <= busy_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result    <= result_next;
    mask      <= mask_next;
    rows      <= rows_next;
    groups    <= groups_next;
    grp       <= grp_next;
    src_base  <= src_base_next;
    dst_base  <= dst_base_next;
    scale     <= scale_next;
    count     <= count_next;
    rem_bytes <= rem_bytes_next;
    bank      <= bank_next;
    row       <= row_next;
    gidx      <= gidx_next;
    src_row   <= src_row_next;
    src_addr  <= src_addr_next;
    dst_addr  <= dst_addr_next;
  end

endmodule

`default_nettype wire

### rtl/core/bank_copy_address_generator.sv
// Step beat: result passes through the input queue and the output register;
// one step per cycle sustained while results are taken and no start is in the divider.
// Start beat: two passes through the shared radix-2 divider driven by the back end;
// a rejected start answers through the input queue and the output register.
// Reset: config returns to 4/16/32, queue empties, no instruction active.
// ----------------------------------------------------------------------------
// bank_copy_address_generator
// Generates bank-to-bank transfer commands for a copy instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_copy_address_generator import bca_pkg::*; #(
  parameter int BANKS_PER_GROUP = BANKS_PER_GROUP_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result
);

  cfg_t     cfg;
  logic     head_valid;
  qitem_t   head;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bank_groups  <= BANK_GROUPS_RST;
      cfg.in_parallel  <= IN_PARALLEL_RST;
      cfg.out_parallel <= OUT_PARALLEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BANK_GROUPS:  cfg.bank_groups  <= cfg_data[BGRP_W-1:0];
        CFG_IN_PARALLEL:  cfg.in_parallel  <= cfg_data[INPAR_W-1:0];
        CFG_OUT_PARALLEL: cfg.out_parallel <= cfg_data[OUTPAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bca_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bca_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  bca_back #(
    .BANKS_PER_GROUP (BANKS_PER_GROUP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("back end popped an empty queue");

  a_bad_is_bare: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_request |->
      !result.transfer_valid && !result.last_transfer && (result.byte_count == '0))
    else $error("rejected start carries transfer fields");

  a_last_is_transfer: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_transfer |-> result.transfer_valid)
    else $error("last flag without a transfer");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Bank copy address generator testbench
// Drives copy instructions and steps through the item channel, writes the
// configuration registers between phases, and checks every returned
// result against an in-bench prediction of the address walk.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX = BANKS_PER_GROUP_DEF;

  class copy_command_scoreboard;
    int unsigned bank_groups, in_par, out_par;
    bit          busy;
    int unsigned mask, rows, groups, src_group, src_base, dst_base;
    int unsigned scale, count, rem_bytes;
    int unsigned bank, row, grp;
    result_t     expected_cmds[$];
    int          errors, starts, rejects, transfers, finals, idles, reg_writes;

    function new();
      bank_groups = BANK_GROUPS_RST;
      in_par      = IN_PARALLEL_RST;
      out_par     = OUT_PARALLEL_RST;
      busy = 0;
      mask = 0; rows = 0; groups = 0; src_group = 0; src_base = 0; dst_base = 0;
      scale = 0; count = 0; rem_bytes = 0; bank = 0; row = 0; grp = 0;
      errors = 0; starts = 0; rejects = 0; transfers = 0; finals = 0; idles = 0;
      reg_writes = 0;
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void write_config(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_BANK_GROUPS:  bank_groups = data[BGRP_W-1:0];
        CFG_IN_PARALLEL:  in_par      = data[INPAR_W-1:0];
        CFG_OUT_PARALLEL: out_par     = data[OUTPAR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned first_bank_from(int unsigned from);
      for (int unsigned b = from; b < PIX; b++) begin
        if (mask[b]) return b;
      end
      return PIX;
    endfunction

    function void note_item(item_t it);
      result_t     r;
      int unsigned rem;
      bit          last_group, last_row, fin;
      r = '0;
      if (it.action == 1'b0) begin
        starts++;
        busy = 0;
        if (it.source_group >= bank_groups || out_par < in_par || in_par == 0) begin
          rejects++;
          r.bad_request = 1'b1;
          expected_cmds.push_back(r);
          return;
        end
        rows      = it.row_count;
        groups    = it.channel_groups;
        src_group = it.source_group;
        src_base  = it.source_base;
        dst_base  = it.dest_base;
        mask      = it.bank_mask;
        scale     = out_par / in_par;
        rem       = groups % scale;
        count     = groups / scale + (rem != 0 ? 1 : 0);
        rem_bytes = (rem != 0) ? ((in_par * rem) & 'h1FF) : out_par;
        bank = first_bank_from(0);
        row  = 0;
        grp  = 0;
        busy = bank < PIX && rows != 0 && count != 0;
        return;
      end
      if (!busy) begin
        idles++;
        expected_cmds.push_back(r);
        return;
      end
      transfers++;
      last_group = (grp + 1 == count);
      last_row   = (row + 1 == rows);
      fin        = 0;
      r.transfer_valid = 1'b1;
      r.src_bank   = BANK_ID_W'(src_group * PIX + bank);
      r.src_addr   = ADDR_W'(src_base + row * groups + grp * scale);
      r.dst_bank   = BANK_ID_W'((bank_groups - 1) * PIX + bank);
      r.dst_addr   = ADDR_W'(dst_base + row * count + grp);
      r.byte_count = BYTES_W'(last_group ? rem_bytes : out_par);
      if (!last_group) begin
        grp++;
      end else if (!last_row) begin
        grp = 0;
        row++;
      end else begin
        grp  = 0;
        row  = 0;
        bank = first_bank_from(bank + 1);
        if (bank >= PIX) begin
          fin  = 1;
          busy = 0;
          bank = 0;
          finals++;
        end
      end
      r.last_transfer = fin;
      expected_cmds.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_cmds.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      compare("transfer_valid", want.transfer_valid, got.transfer_valid);
      compare("bad_request", want.bad_request, got.bad_request);
      compare("src_bank", want.src_bank, got.src_bank);
      compare("src_addr", want.src_addr, got.src_addr);
      compare("dst_bank", want.dst_bank, got.dst_bank);
      compare("dst_addr", want.dst_addr, got.dst_addr);
      compare("byte_count", want.byte_count, got.byte_count);
      compare("last_transfer", want.last_transfer, got.last_transfer);
    endfunction

    function void report();
      if (expected_cmds.size() != 0) begin
        $error("%0d expected results never arrived", expected_cmds.size());
        errors++;
      end
      $display("run covered %0d starts (%0d rejected), %0d transfers (%0d final),",
               starts, rejects, transfers, finals);
      $display("  %0d idle steps and %0d register writes", idles, reg_writes);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic       item_valid;
  logic       item_ready;
  item_t      item;
  logic       result_valid;
  logic       result_ready;
  result_t    result;

  bit calm = 0;
  bit hold_request = 0;

  copy_command_scoreboard commands = new();

  bank_copy_address_generator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) commands.write_config(cfg_index, cfg_data);
      if (item_valid && item_ready) commands.note_item(item);
      if (result_valid && result_ready) commands.check_result(result);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        result_ready <= 1'b0;
        repeat (200) @(posedge clk);
        result_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // valid stays up between beats unless a random gap is inserted; callers drop it afterwards
  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    while (commands.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
  endtask

  function automatic item_t random_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t step_item();
    item_t it;
    it = random_item();
    it.action = 1'b1;
    return it;
  endfunction

  task automatic send_steps(input int n);
    repeat (n) send_item(step_item());
  endtask

  task automatic send_start(input int rows, groups, sgrp, sbase, dbase, mask);
    item_t it;
    it = '0;
    it.row_count      = ROWS_W'(rows);
    it.channel_groups = GROUPS_W'(groups);
    it.source_group   = SGRP_W'(sgrp);
    it.source_base    = ADDR_W'(sbase);
    it.dest_base      = ADDR_W'(dbase);
    it.bank_mask      = MASK_W'(mask);
    send_item(it);
  endtask

  function automatic item_t random_start();
    item_t       it;
    int unsigned sc, sel;
    it = random_item();
    it.action = 1'b0;
    sel = $urandom_range(0, 9);
    sc  = (commands.in_par != 0 && commands.out_par >= commands.in_par) ?
          commands.out_par / commands.in_par : 1;
    if (sel == 1) begin
      if (commands.bank_groups <= 15)
        it.source_group = SGRP_W'($urandom_range(commands.bank_groups, 15));
    end else if (sel != 0) begin
      it.source_group   = SGRP_W'($urandom_range(0, commands.bank_groups - 1));
      it.row_count      = ROWS_W'($urandom_range(1, 3));
      it.channel_groups = GROUPS_W'($urandom_range(1, (3 * sc > 255) ? 255 : 3 * sc));
      it.bank_mask      = MASK_W'($urandom() & $urandom());
    end
    return it;
  endfunction

  function automatic int plan_steps(item_t it);
    int unsigned sc, cnt, total;
    if (it.source_group >= commands.bank_groups || commands.in_par == 0 ||
        commands.out_par < commands.in_par)
      return $urandom_range(0, 2);
    sc    = commands.out_par / commands.in_par;
    cnt   = (it.channel_groups + sc - 1) / sc;
    total = $countones(it.bank_mask) * it.row_count * cnt;
    if (total > 24 || $urandom_range(0, 4) == 0) return $urandom_range(1, 24);
    return total + $urandom_range(0, 2);
  endfunction

  // bank_groups changes under a running instruction; the parallelism
  // registers only once the instruction has been cleared
  task automatic reconfigure(input int bg, ip, op);
    settle();
    write_reg(CFG_BANK_GROUPS, bg);
    cfg_valid <= 1'b0;
    send_steps(3);
    send_start(0, 0, 0, 0, 0, 0);
    item_valid <= 1'b0;
    settle();
    write_reg(CFG_IN_PARALLEL, ip);
    write_reg(CFG_OUT_PARALLEL, op);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int bg, ip, op, budget, input bit with_hold);
    int    sent, n;
    item_t it;
    sent = 0;
    reconfigure(bg, ip, op);
    while (sent < budget) begin
      if (with_hold && sent >= budget / 2) begin
        hold_request = 1;
        with_hold = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(random_item());
        sent++;
      end else begin
        it = random_start();
        n  = plan_steps(it);
        send_item(it);
        send_steps(n);
        sent += n + 1;
      end
    end
    item_valid <= 1'b0;
  endtask

  initial begin
    int rip, rop;
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_BANK_GROUPS;
    cfg_data   <= '0;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle step, rejected group, wrapping walk over banks 0 and 7
    send_steps(1);
    send_start(1, 1, 4, 0, 0, 1);
    send_start(2, 3, 3, 'hFFFE, 'hFFFF, 'h81);
    send_steps(9);
    // empty instructions
    send_start(5, 5, 1, 0, 0, 0);
    send_start(0, 5, 1, 0, 0, 'hFF);
    send_start(5, 0, 1, 0, 0, 'hFF);
    send_steps(1);
    // largest instruction, then replaced while running
    send_start(4095, 255, 3, 0, 0, 'hFF);
    send_steps(3);
    send_start(1, 2, 0, 'h1234, 'h4321, 'h40);
    send_steps(2);
    item_valid <= 1'b0;

    // zero input parallelism rejects every start
    reconfigure(4, 0, 32);
    send_start(1, 1, 0, 0, 0, 1);
    send_steps(1);
    item_valid <= 1'b0;

    rip = $urandom_range(1, 64);
    rop = $urandom_range(rip, 256);
    run_phase(16, 1, 256, 60, 0);
    run_phase(1, 64, 64, 60, 0);
    run_phase(4, 64, 32, 15, 0);
    run_phase($urandom_range(1, 16), rip, rop, 60, 0);
    run_phase(16, 64, 256, 55, 1);
    settle();
    calm = 1;
    rip = $urandom_range(1, 16);
    rop = $urandom_range(rip, 256);
    run_phase($urandom_range(1, 16), rip, rop, 55, 0);

    settle();
    commands.report();
    if (commands.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/core/bca_pkg.sv
rtl/core/bca_front.sv
rtl/core/bca_div.sv
rtl/core/bca_back.sv
rtl/core/bank_copy_address_generator.sv
tb/testbench.sv
